// ----- sv/baar_pkg.sv -----
package baar_pkg;

    // fixed field widths
    localparam int BTN_W = 24;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REPEAT_DELAY    = 1'b0,
        REG_REPEAT_INTERVAL = 1'b1
    } cfg_reg_t;

    // one result word, levels in the lowest bits
    typedef struct packed {
        logic [BTN_W-1:0] repeat_pulse;
        logic [BTN_W-1:0] released;
        logic [BTN_W-1:0] pressed;
        logic [BTN_W-1:0] levels;
    } result_t;

endpackage

// ----- sv/button_edge_and_auto_repeat.sv -----
// Button edge detector with typematic auto-repeat. Each input word is one
// polled frame of 24 button levels (1 = down). For every frame the block
// returns the levels, the buttons pressed and released since the previous
// frame, and auto-repeat pulses: a held button pulses on the press frame,
// again once its hold counter exceeds repeat_delay, and after that each
// time the counter exceeds repeat_interval; releasing it clears its repeat
// state. Hold counters are COUNT_BITS wide and saturate, so a register at
// or above the counter maximum disables that repeat stage. Buttons at or
// above NUM_BUTTONS (and any above 24) never repeat. Rate: one frame per
// clock cycle, sustained while downstream accepts results; each button
// has its own counter and compare logic, all evaluated in parallel in the
// cycle a frame moves from the input register to the result register. A
// frame is registered in the input register, then in the result register,
// from which it leaves. The input register can still take one frame while
// a finished result waits for downstream. Write repeat_delay (index 0) and
// repeat_interval (index 1) only while no frame is in flight.
module button_edge_and_auto_repeat #(
    parameter int NUM_BUTTONS = 24,
    parameter int COUNT_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration writes
    input  logic                            cfg_we,
    input  logic [baar_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [baar_pkg::CFG_W-1:0]      cfg_wdata,
    // frame input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // buttons[23:0]
    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [95:0]                     m_tdata    // levels[23:0], pressed[47:24],
                                                       // released[71:48], repeat_pulse[95:72]
);

    // buttons that actually have counters
    localparam int ACTIVE = (NUM_BUTTONS < baar_pkg::BTN_W) ? NUM_BUTTONS : baar_pkg::BTN_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [baar_pkg::BTN_W-1:0] ACTIVE_MASK = baar_pkg::BTN_W'({ACTIVE{1'b1}});

    // configuration registers
    logic [baar_pkg::CFG_W-1:0] delay_reg;
    logic [baar_pkg::CFG_W-1:0] interval_reg;

    // input stage
    logic                       in_valid_reg;
    logic [baar_pkg::BTN_W-1:0] in_data_reg;

    // per-button state
    logic [baar_pkg::BTN_W-1:0] prev_reg;
    logic [baar_pkg::BTN_W-1:0] mode_reg;
    logic [baar_pkg::BTN_W-1:0] mode_next;
    logic [COUNT_BITS-1:0]      cnt_reg  [ACTIVE];
    logic [COUNT_BITS-1:0]      cnt_next [ACTIVE];

    // result stage
    logic                       out_valid_reg;
    baar_pkg::result_t          out_reg;
    baar_pkg::result_t          out_next;

    logic [baar_pkg::BTN_W-1:0] rise;
    logic [baar_pkg::BTN_W-1:0] pulse;
    logic                       advance;

    // the input stage moves on when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    assign rise = in_data_reg & ~prev_reg;

    // per-button repeat logic
    genvar j;
    generate
        for (j = 0; j < ACTIVE; j++) begin : g_btn
            logic                       fire_interval;
            logic                       fire_delay;
            logic [COUNT_BITS-1:0]      cnt_mid;

            assign fire_interval = baar_pkg::CFG_W'(cnt_reg[j]) > interval_reg;
            assign fire_delay    = baar_pkg::CFG_W'(cnt_reg[j]) > delay_reg;

            always_comb
            begin
                cnt_mid      = cnt_reg[j];
                pulse[j]     = 1'b0;
                mode_next[j] = mode_reg[j];
                if (in_data_reg[j])
                begin
                    if (mode_reg[j])
                    begin
                        if (fire_interval)
                        begin
                            pulse[j] = 1'b1;
                            cnt_mid  = '0;
                        end
                    end
                    else if (fire_delay)
                    begin
                        pulse[j]     = 1'b1;
                        mode_next[j] = 1'b1;
                        cnt_mid      = '0;
                    end
                    else
                    begin
                        pulse[j] = rise[j];
                    end
                    // saturating count of held frames
                    cnt_next[j] = (cnt_mid == CNT_MAX) ? cnt_mid : cnt_mid + 1'b1;
                end
                else
                begin
                    cnt_next[j]  = '0;
                    mode_next[j] = 1'b0;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cnt_reg[j] <= '0;
                end
                else if (advance)
                begin
                    cnt_reg[j] <= cnt_next[j];
                end
            end
        end

        // buttons without counters never repeat
        for (j = ACTIVE; j < baar_pkg::BTN_W; j++) begin : g_idle
            assign pulse[j]     = 1'b0;
            assign mode_next[j] = 1'b0;
        end
    endgenerate

    always_comb
    begin
        out_next.levels       = in_data_reg;
        out_next.pressed      = rise;
        out_next.released     = ~in_data_reg & prev_reg;
        out_next.repeat_pulse = pulse;
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= '0;
            interval_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (baar_pkg::cfg_reg_t'(cfg_addr))
                baar_pkg::REG_REPEAT_DELAY:    delay_reg    <= cfg_wdata;
                baar_pkg::REG_REPEAT_INTERVAL: interval_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input stage, frame state and result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
            mode_reg      <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                prev_reg      <= in_data_reg;
                mode_reg      <= mode_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    // repeat mode only survives on buttons still held
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg & ~prev_reg) == '0)
        else $error("repeat mode set on a released button");

    // a result never reports a pulse on a button that is up
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_reg.repeat_pulse & ~out_reg.levels) == '0))
        else $error("repeat pulse on a button that is up");

    // every press on a button that has a counter produces a pulse
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_reg.pressed & ~out_reg.repeat_pulse & ACTIVE_MASK) == '0))
        else $error("press without a repeat pulse");

    // consecutive results chain their edges through the previous levels
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_reg.pressed == (out_reg.levels & ~$past(prev_reg))))
        else $error("pressed does not match the stored levels");

endmodule
